// ===== design/rcfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_pkg - shared types and constants of the RC receiver frame decoder
// Holds the frame geometry, request and status codes, register map, the
// configuration and result records and the blank-result helper.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  // Burst store geometry
  localparam int BUF_BYTES   = 36;
  localparam int FRAME_BYTES = 18;
  localparam int CNT_W       = $clog2(BUF_BYTES + 1);
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  // Field widths
  localparam int STICK_W = 11;
  localparam int WORD_W  = 16;
  localparam int SW_W    = 2;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_CHANNEL_OFFSET = 2'd0;
  localparam logic [1:0] REG_DEADBAND       = 2'd1;
  localparam logic [1:0] REG_ERROR_LIMIT    = 2'd2;
  localparam logic [1:0] REG_LOST_TICKS     = 2'd3;

  localparam logic [10:0] RST_CHANNEL_OFFSET = 11'd1024;
  localparam logic [9:0]  RST_DEADBAND       = 10'd5;
  localparam logic [9:0]  RST_ERROR_LIMIT    = 10'd700;
  localparam logic [15:0] RST_LOST_TICKS     = 16'd50;

  // Switch position reported when a frame is bad or the link is gone
  localparam logic [SW_W-1:0] SW_DOWN = 2'd2;
  localparam logic [SW_W-1:0] SW_NONE = 2'd0;

  // Input word kinds
  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_IDLE = 2'd1,
    REQ_TICK = 2'd2
  } rcfd_req_t;

  // Result status
  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_ERROR = 2'd1,
    STAT_LOST  = 2'd2
  } rcfd_status_t;

  typedef logic [FRAME_BYTES-1:0][7:0] rcfd_frame_t;

  typedef struct packed {
    logic [10:0] channel_offset;
    logic [9:0]  deadband;
    logic [9:0]  error_limit;
    logic [15:0] lost_ticks;
  } rcfd_cfg_t;

  typedef struct packed {
    logic [STICK_W-1:0] stick_right_h;
    logic [STICK_W-1:0] stick_right_v;
    logic [STICK_W-1:0] stick_left_h;
    logic [STICK_W-1:0] stick_left_v;
    logic [WORD_W-1:0]  wheel_channel;
    logic [3:0]         switch_pair;
    logic [WORD_W-1:0]  mouse_dx;
    logic [WORD_W-1:0]  mouse_dy;
    logic [WORD_W-1:0]  mouse_dz;
    logic [WORD_W-1:0]  mouse_buttons;
    logic [WORD_W-1:0]  key_bits;
    rcfd_status_t       frame_status;
  } rcfd_result_t;

  // All data zero, both switches down, given status
  function automatic rcfd_result_t blank_result(input rcfd_status_t st);
    rcfd_result_t r;
    r              = '0;
    r.switch_pair  = {SW_DOWN, SW_DOWN};
    r.frame_status = st;
    return r;
  endfunction

endpackage

// ===== design/rcfd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_cfg_regs - configuration register file
// APB-style slave holding channel offset, deadband, error limit and loss
// timeout; zero wait states, reads return the stored value.
// ----------------------------------------------------------------------------
module rcfd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcfd_pkg::APB_AW-1:0] paddr,
  input  logic [rcfd_pkg::APB_DW-1:0] pwdata,
  output logic [rcfd_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output rcfd_pkg::rcfd_cfg_t         cfg
);
  import rcfd_pkg::*;

  rcfd_cfg_t  cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Update the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_CHANNEL_OFFSET: cfg_nxt.channel_offset = pwdata[10:0];
        REG_DEADBAND:       cfg_nxt.deadband       = pwdata[9:0];
        REG_ERROR_LIMIT:    cfg_nxt.error_limit    = pwdata[9:0];
        REG_LOST_TICKS:     cfg_nxt.lost_ticks     = pwdata[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_offset <= RST_CHANNEL_OFFSET;
      cfg_r.deadband       <= RST_DEADBAND;
      cfg_r.error_limit    <= RST_ERROR_LIMIT;
      cfg_r.lost_ticks     <= RST_LOST_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_CHANNEL_OFFSET: prdata = APB_DW'(cfg_r.channel_offset);
      REG_DEADBAND:       prdata = APB_DW'(cfg_r.deadband);
      REG_ERROR_LIMIT:    prdata = APB_DW'(cfg_r.error_limit);
      REG_LOST_TICKS:     prdata = APB_DW'(cfg_r.lost_ticks);
      default:            prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== design/rcfd_frame_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_frame_buf - burst byte store and byte counter
// Collects the bytes of the current burst. The count saturates at the
// buffer size; only the leading frame-length bytes are kept, since a frame
// is decoded only from a burst of exactly that length.
// ----------------------------------------------------------------------------
module rcfd_frame_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_en,
  input  logic [7:0]                 rx_byte,
  input  logic                       clear,
  output rcfd_pkg::rcfd_frame_t      frame,
  output logic [rcfd_pkg::CNT_W-1:0] byte_cnt
);
  import rcfd_pkg::*;

  rcfd_frame_t      store_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             room;
  logic             keep;

  assign room = cnt_r < CNT_W'(BUF_BYTES);
  assign keep = byte_en && (cnt_r < CNT_W'(FRAME_BYTES));

  // Advance or clear the count
  always_comb begin
    cnt_nxt = cnt_r;
    if (clear) begin
      cnt_nxt = '0;
    end else if (byte_en && room) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Write the byte into its slot
  always_ff @(posedge clk) begin
    if (keep) begin
      store_r[cnt_r[IDX_W-1:0]] <= rx_byte;
    end
  end

  assign frame    = store_r;
  assign byte_cnt = cnt_r;

endmodule

// ===== design/rcfd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_decode - frame field decoder
// Slices sticks, switches, mouse, keys and wheel from a stored frame,
// applies offset and deadband, and flags out-of-range sticks or an unset
// switch.
// ----------------------------------------------------------------------------
module rcfd_decode (
  input  rcfd_pkg::rcfd_frame_t  frame,
  input  rcfd_pkg::rcfd_cfg_t    cfg,
  output rcfd_pkg::rcfd_result_t result,
  output logic                   frame_err
);
  import rcfd_pkg::*;

  logic [3:0][STICK_W-1:0] raw;
  logic [3:0][STICK_W:0]   stick;
  logic [3:0]              over;
  logic [SW_W-1:0]         sw_l, sw_r;
  logic [STICK_W:0]        off_ext, db_ext, lim_ext;
  logic [WORD_W-1:0]       wheel_raw;

  // Unpack the 11-bit channels
  assign raw[0] = {frame[1][2:0], frame[0]};
  assign raw[1] = {frame[2][5:0], frame[1][7:3]};
  assign raw[2] = {frame[4][0],   frame[3], frame[2][7:6]};
  assign raw[3] = {frame[5][3:0], frame[4][7:1]};
  assign sw_l   = frame[5][7:6];
  assign sw_r   = frame[5][5:4];

  assign off_ext = {1'b0, cfg.channel_offset};
  assign db_ext  = {2'b00, cfg.deadband};
  assign lim_ext = {2'b00, cfg.error_limit};

  // Per stick: subtract center, apply deadband, check magnitude
  always_comb begin
    logic signed [STICK_W:0] diff;
    logic signed [STICK_W:0] dz;
    logic signed [STICK_W:0] v;
    logic        [STICK_W:0] m;
    for (int k = 0; k < 4; k++) begin
      diff     = $signed({1'b0, raw[k]}) - $signed(off_ext);
      dz       = $signed(db_ext);
      v        = ((diff > dz) || (diff < -dz)) ? diff : '0;
      m        = v[STICK_W] ? unsigned'(-v) : unsigned'(v);
      stick[k] = unsigned'(v);
      over[k]  = m > lim_ext;
    end
  end

  assign frame_err = (|over) || (sw_l == SW_NONE) || (sw_r == SW_NONE);

  assign wheel_raw = {frame[17], frame[16]};

  // Assemble the decoded word
  always_comb begin
    result               = '0;
    result.stick_right_h = stick[0][STICK_W-1:0];
    result.stick_right_v = stick[1][STICK_W-1:0];
    result.stick_left_h  = stick[2][STICK_W-1:0];
    result.stick_left_v  = stick[3][STICK_W-1:0];
    result.wheel_channel = wheel_raw - WORD_W'(cfg.channel_offset);
    result.switch_pair   = {sw_l, sw_r};
    result.mouse_dx      = {frame[7],  frame[6]};
    result.mouse_dy      = {frame[9],  frame[8]};
    result.mouse_dz      = {frame[11], frame[10]};
    result.mouse_buttons = {frame[13], frame[12]};
    result.key_bits      = {frame[15], frame[14]};
    result.frame_status  = STAT_VALID;
  end

endmodule

// ===== design/rcfd_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_out_queue - two-entry result buffer
// Head register drives the output; a second slot takes a new result while
// the head waits, so the input side keeps moving under back-pressure.
// ----------------------------------------------------------------------------
module rcfd_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rcfd_pkg::rcfd_result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rcfd_pkg::rcfd_result_t out_data
);
  import rcfd_pkg::*;

  rcfd_result_t head_r, head_nxt, tail_r, tail_nxt;
  logic         head_vld_r, head_vld_nxt, tail_vld_r, tail_vld_nxt;
  logic         pop;

  assign pop = head_vld_r & out_ready;

  // Shift on pop, fill the first free slot on push
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    head_vld_nxt = head_vld_r;
    tail_vld_nxt = tail_vld_r;
    if (pop) begin
      if (tail_vld_r) begin
        head_nxt     = tail_r;
        head_vld_nxt = 1'b1;
        tail_nxt     = push_data;
        tail_vld_nxt = push;
      end else begin
        head_nxt     = push_data;
        head_vld_nxt = push;
      end
    end else if (push) begin
      if (!head_vld_r) begin
        head_nxt     = push_data;
        head_vld_nxt = 1'b1;
      end else begin
        tail_nxt     = push_data;
        tail_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      tail_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      tail_vld_r <= tail_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign full      = tail_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

endmodule

// ===== design/rc_receiver_frame_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_top - RC receiver frame decoder
//
//   Port group  Direction  Content
//   in_*        slave      one word: received byte, line idle or time tick
//   out_*       master     one decoded, error or link-lost result word
//   p*          APB slave  offset, deadband, error limit, loss timeout
//
// One input word is taken per cycle while in_tready is high; a result shows
// on out_tvalid once it heads the output buffer. The decode is a single pass
// from the byte store through the decoder into the two-entry output buffer.
// in_tready drops only while both output slots hold results not yet taken.
// Reset is synchronous: count, link state, output buffer and registers clear.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input words
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]                  in_tuser,   // [1:0] req_type
  // Results
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [10:0] stick_right_h, [21:11] stick_right_v, [32:22] stick_left_h,
  // [43:33] stick_left_v, [59:44] wheel_channel, [63:60] switch_pair,
  // [79:64] mouse_dx, [95:80] mouse_dy, [111:96] mouse_dz,
  // [127:112] mouse_buttons, [143:128] key_bits
  output logic [143:0]                out_tdata,
  output logic [1:0]                  out_tuser,  // [1:0] frame_status
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcfd_pkg::APB_AW-1:0] paddr,
  input  logic [rcfd_pkg::APB_DW-1:0] pwdata,
  output logic [rcfd_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import rcfd_pkg::*;

  rcfd_cfg_t        cfg;
  rcfd_frame_t      frame;
  logic [CNT_W-1:0] byte_cnt;
  rcfd_result_t     dec_result, res, head;
  logic             dec_err;
  logic             accept, is_byte, is_idle, is_tick;
  logic             frame_ready, tick_lost, res_vld, q_full;
  logic [15:0]      countdown_r, countdown_nxt;
  logic             link_up_r, link_up_nxt;

  assign accept  = in_tvalid & in_tready;
  assign is_byte = accept && (in_tuser == REQ_BYTE);
  assign is_idle = accept && (in_tuser == REQ_IDLE);
  assign is_tick = accept && (in_tuser == REQ_TICK);

  rcfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcfd_frame_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (is_byte),
    .rx_byte  (in_tdata),
    .clear    (is_idle),
    .frame    (frame),
    .byte_cnt (byte_cnt)
  );

  rcfd_decode u_dec (
    .frame     (frame),
    .cfg       (cfg),
    .result    (dec_result),
    .frame_err (dec_err)
  );

  // Decode on an idle event that closes a burst of exactly one frame
  assign frame_ready = is_idle && (byte_cnt == CNT_W'(FRAME_BYTES));
  assign tick_lost   = is_tick && link_up_r && (countdown_r <= 16'd1);
  assign res_vld     = frame_ready || tick_lost;

  // Select the result word
  always_comb begin
    if (tick_lost) begin
      res = blank_result(STAT_LOST);
    end else if (dec_err) begin
      res = blank_result(STAT_ERROR);
    end else begin
      res = dec_result;
    end
  end

  // Reload on a good frame, count down on ticks, drop the link on expiry
  always_comb begin
    countdown_nxt = countdown_r;
    link_up_nxt   = link_up_r;
    if (frame_ready && !dec_err) begin
      countdown_nxt = cfg.lost_ticks;
      link_up_nxt   = 1'b1;
    end else if (tick_lost) begin
      countdown_nxt = '0;
      link_up_nxt   = 1'b0;
    end else if (is_tick && link_up_r) begin
      countdown_nxt = countdown_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= '0;
      link_up_r   <= 1'b0;
    end else begin
      countdown_r <= countdown_nxt;
      link_up_r   <= link_up_nxt;
    end
  end

  rcfd_out_queue u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign in_tready = ~q_full;

  // Pack the result word, first field lowest
  assign out_tdata = {head.key_bits, head.mouse_buttons, head.mouse_dz, head.mouse_dy,
                      head.mouse_dx, head.switch_pair, head.wheel_channel,
                      head.stick_left_v, head.stick_left_h, head.stick_right_v,
                      head.stick_right_h};
  assign out_tuser = head.frame_status;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the RC receiver frame decoder
// Streams byte, line-idle and tick words into the decoder and predicts every
// decoded, error and link-lost report from a local model of the burst store,
// the loss countdown and the register set. A short directed run is followed
// by random traffic under several register settings and flow-control mixes.
// Every report is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import rcfd_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASE_WORDS    = 210;

  // Word kind that the decoder must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
  } rc_word_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_tvalid     = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata      = '0;   // [7:0] rx_byte
  logic [1:0]          in_tuser      = '0;   // [1:0] req_type
  logic                out_tvalid;
  logic                out_tready    = 1'b0;
  // [10:0] stick_right_h, [21:11] stick_right_v, [32:22] stick_left_h,
  // [43:33] stick_left_v, [59:44] wheel_channel, [63:60] switch_pair,
  // [79:64] mouse_dx, [95:80] mouse_dy, [111:96] mouse_dz,
  // [127:112] mouse_buttons, [143:128] key_bits
  logic [143:0]        out_tdata;
  logic [1:0]          out_tuser;          // [1:0] frame_status
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Stimulus and flow control
  rc_word_t            rx_words[$];
  rc_word_t            next_word;
  logic                word_taken    = 1'b0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_req      = 1'b0;
  bit                  hold_on       = 1'b0;

  // Decoder model state
  rcfd_cfg_t           cfg_model;
  logic [7:0]          burst_bytes[BUF_BYTES];
  int unsigned         burst_len     = 0;
  int unsigned         loss_left     = 0;
  bit                  link_alive    = 1'b0;
  rcfd_result_t        expected_reports[$];

  // Run statistics
  int                  failures      = 0;
  int                  words_seen    = 0;
  int                  n_valid       = 0;
  int                  n_error       = 0;
  int                  n_lost        = 0;

  rc_receiver_frame_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the model by one accepted word and queue any report it causes
  function automatic void decode_word(input logic [1:0] kind, input logic [7:0] data);
    rcfd_result_t res;
    logic [47:0]  head;
    logic [10:0]  st[4];
    int           v;
    int           mag;
    bit           bad;
    res = '0;
    bad = 1'b0;
    case (kind)
      REQ_BYTE: begin
        if (burst_len < BUF_BYTES) begin
          burst_bytes[burst_len] = data;
          burst_len++;
        end
      end
      REQ_TICK: begin
        if (link_alive) begin
          if (loss_left <= 1) begin
            loss_left          = 0;
            link_alive         = 1'b0;
            res.switch_pair    = {SW_DOWN, SW_DOWN};
            res.frame_status   = STAT_LOST;
            expected_reports.push_back(res);
          end else begin
            loss_left--;
          end
        end
      end
      REQ_IDLE: begin
        if (burst_len == FRAME_BYTES) begin
          for (int i = 0; i < 6; i++) head[8*i +: 8] = burst_bytes[i];
          // Center, deadband and range-check each stick at full width
          for (int k = 0; k < 4; k++) begin
            v = int'(head[11*k +: 11]) - int'(cfg_model.channel_offset);
            if (v <= int'(cfg_model.deadband) && v >= -int'(cfg_model.deadband)) v = 0;
            mag = (v < 0) ? -v : v;
            if (mag > int'(cfg_model.error_limit)) bad = 1'b1;
            st[k] = v[10:0];
          end
          if (head[47:46] == SW_NONE || head[45:44] == SW_NONE) bad = 1'b1;
          if (bad) begin
            res.switch_pair  = {SW_DOWN, SW_DOWN};
            res.frame_status = STAT_ERROR;
          end else begin
            loss_left          = 32'(cfg_model.lost_ticks);
            link_alive         = 1'b1;
            res.stick_right_h  = st[0];
            res.stick_right_v  = st[1];
            res.stick_left_h   = st[2];
            res.stick_left_v   = st[3];
            res.wheel_channel  = {burst_bytes[17], burst_bytes[16]}
                                 - 16'(cfg_model.channel_offset);
            res.switch_pair    = head[47:44];
            res.mouse_dx       = {burst_bytes[7], burst_bytes[6]};
            res.mouse_dy       = {burst_bytes[9], burst_bytes[8]};
            res.mouse_dz       = {burst_bytes[11], burst_bytes[10]};
            res.mouse_buttons  = {burst_bytes[13], burst_bytes[12]};
            res.key_bits       = {burst_bytes[15], burst_bytes[14]};
            res.frame_status   = STAT_VALID;
          end
          expected_reports.push_back(res);
        end
        burst_len = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic void check_report(input rcfd_result_t want, input logic [143:0] d,
                                       input logic [1:0] u);
    check_field("stick_right_h", 16'(want.stick_right_h), 16'(d[10:0]));
    check_field("stick_right_v", 16'(want.stick_right_v), 16'(d[21:11]));
    check_field("stick_left_h",  16'(want.stick_left_h),  16'(d[32:22]));
    check_field("stick_left_v",  16'(want.stick_left_v),  16'(d[43:33]));
    check_field("wheel_channel", want.wheel_channel, d[59:44]);
    check_field("switch_pair",   16'(want.switch_pair),   16'(d[63:60]));
    check_field("mouse_dx",      want.mouse_dx,      d[79:64]);
    check_field("mouse_dy",      want.mouse_dy,      d[95:80]);
    check_field("mouse_dz",      want.mouse_dz,      d[111:96]);
    check_field("mouse_buttons", want.mouse_buttons, d[127:112]);
    check_field("key_bits",      want.key_bits,      d[143:128]);
    check_field("frame_status",  16'(want.frame_status),  16'(u));
  endfunction

  function automatic void queue_word(input logic [1:0] kind, input logic [7:0] data);
    rc_word_t w;
    w.kind = kind;
    w.data = data;
    rx_words.push_back(w);
  endfunction

  function automatic rcfd_frame_t make_frame(input logic [10:0] rh, rv, lh, lv,
                                             input logic [1:0] sw_l, sw_r,
                                             input logic [95:0] tail);
    rcfd_frame_t fr;
    fr[5:0]  = {sw_l, sw_r, lv, lh, rv, rh};
    fr[17:6] = tail;
    return fr;
  endfunction

  // Queue one burst of frame bytes, optionally with a tick inside it
  function automatic void push_frame(input rcfd_frame_t fr, input int tick_at);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i == tick_at) queue_word(REQ_TICK, 8'($urandom));
      queue_word(REQ_BYTE, fr[i]);
    end
    queue_word(REQ_IDLE, 8'($urandom));
  endfunction

  function automatic void push_burst(input int n_bytes);
    repeat (n_bytes) queue_word(REQ_BYTE, 8'($urandom));
    queue_word(REQ_IDLE, 8'($urandom));
  endfunction

  // Mostly near center, with the rails and the deadband edges now and then
  function automatic logic [10:0] pick_stick();
    int off;
    int lim;
    int db;
    int v;
    int d;
    off = int'(cfg_model.channel_offset);
    lim = int'(cfg_model.error_limit);
    db  = int'(cfg_model.deadband);
    case ($urandom_range(0, 19))
      0: v = 0;
      1: v = 2047;
      2, 3: begin
        d = db + int'($urandom_range(0, 2)) - 1;
        v = ($urandom_range(0, 1) != 0) ? off + d : off - d;
      end
      default: v = off + int'($urandom_range(0, 2 * lim)) - lim;
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[10:0];
  endfunction

  function automatic rcfd_frame_t random_frame();
    logic [1:0] sw_l;
    logic [1:0] sw_r;
    sw_l = ($urandom_range(0, 19) == 0) ? SW_NONE : 2'($urandom_range(1, 3));
    sw_r = ($urandom_range(0, 19) == 0) ? SW_NONE : 2'($urandom_range(1, 3));
    return make_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                      sw_l, sw_r, {$urandom(), $urandom(), $urandom()});
  endfunction

  // Mostly well-formed frames, with ticks, broken bursts and stray words
  function automatic void queue_random_words(input int target);
    int added;
    int pick;
    int n;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        push_frame(random_frame(),
                   ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 17)) : -1);
        n = $urandom_range(0, 3);
        repeat (n) queue_word(REQ_TICK, 8'($urandom));
        added += FRAME_BYTES + 1 + n;
      end else if (pick < 80) begin
        n = $urandom_range(1, 8);
        repeat (n) queue_word(REQ_TICK, 8'($urandom));
        added += n;
      end else if (pick < 90) begin
        n = $urandom_range(0, BUF_BYTES + 4);
        if (n == FRAME_BYTES) n++;
        push_burst(n);
        added += n + 1;
      end else begin
        queue_word(2'($urandom_range(0, 3)), 8'($urandom));
        added++;
      end
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHANNEL_OFFSET: cfg_model.channel_offset = value[10:0];
      REG_DEADBAND:       cfg_model.deadband       = value[9:0];
      REG_ERROR_LIMIT:    cfg_model.error_limit    = value[9:0];
      REG_LOST_TICKS:     cfg_model.lost_ticks     = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int off, input int db, input int lim, input int ticks);
    write_reg(REG_CHANNEL_OFFSET, 32'(off));
    write_reg(REG_DEADBAND, 32'(db));
    write_reg(REG_ERROR_LIMIT, 32'(lim));
    write_reg(REG_LOST_TICKS, 32'(ticks));
  endtask

  // Hold until every queued word is taken and every report has come back
  task automatic wait_quiet();
    while (rx_words.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_words);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_words(n_words);
    wait_quiet();
  endtask

  // Input driver: present the next word, or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || word_taken) begin
      if (rx_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_word = rx_words.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_word.kind;
        in_tdata  <= next_word.data;
      end else begin
        in_tvalid <= 1'b0;
        in_tuser  <= 2'($urandom);
        in_tdata  <= 8'($urandom);
      end
    end
  end

  // Result-side ready: random stalls plus the long hold-off
  always @(negedge clk) begin
    out_tready <= rst_n && !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : rx_holdoff
    wait (hold_req);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // Sample accepted input words into the model
  always @(posedge clk) begin
    word_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      decode_word(in_tuser, in_tdata);
      words_seen++;
    end
  end

  // Check each accepted report against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("report with none expected: status %0d", out_tuser);
        failures++;
      end else begin
        check_report(expected_reports.pop_front(), out_tdata, out_tuser);
      end
      if (out_tuser == STAT_VALID) n_valid++;
      else if (out_tuser == STAT_ERROR) n_error++;
      else n_lost++;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    cfg_model.channel_offset = RST_CHANNEL_OFFSET;
    cfg_model.deadband       = RST_DEADBAND;
    cfg_model.error_limit    = RST_ERROR_LIMIT;
    cfg_model.lost_ticks     = RST_LOST_TICKS;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: stray tick, unused kind, empty burst, frames at the edges
    queue_word(REQ_TICK, 8'hA5);
    queue_word(REQ_UNUSED, 8'hFF);
    queue_word(REQ_IDLE, 8'h00);
    push_frame(make_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd3,
                          {96{1'b1}}), -1);
    // Center plus deadband, center minus deadband minus one, both limit rails
    push_frame(make_frame(11'd1029, 11'd1018, 11'd1724, 11'd324, 2'd2, 2'd2,
                          {16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001}), -1);
    push_frame(make_frame(11'd1725, 11'd1024, 11'd0, 11'd2047, 2'd3, 2'd3,
                          {96{1'b1}}), -1);
    push_frame(make_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, SW_NONE, 2'd3,
                          {96{1'b1}}), -1);
    // Short burst, then an overflowing one, then a clean frame
    push_burst(FRAME_BYTES - 1);
    push_burst(BUF_BYTES + 1);
    push_frame(make_frame(11'd1030, 11'd1018, 11'd1500, 11'd600, 2'd3, 2'd1,
                          {$urandom(), $urandom(), $urandom()}), -1);
    wait_quiet();

    // Reset offset, deadband and limit with a short timeout, back-to-back traffic and a long receiver hold-off
    apply_settings(1024, 5, 700, 3);
    hold_req = 1'b1;
    run_phase(0, 0, PHASE_WORDS);

    apply_settings(0, 0, 1023, 1);
    run_phase(48, 0, PHASE_WORDS);

    apply_settings(2047, 1023, 0, 65535);
    run_phase(0, 48, PHASE_WORDS);

    // Zero timeout: the first tick after a good frame drops the link
    apply_settings(1000, 30, 650, 0);
    run_phase(30, 30, PHASE_WORDS);

    $display("Covered %0d input words across five register settings and four flow mixes.",
             words_seen);
    $display("Checked %0d decoded, %0d error and %0d link-lost reports.",
             n_valid, n_error, n_lost);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
